>>> src/bpt_pkg.sv
`timescale 1ns / 1ps

package bpt_pkg;

    // Table size and field widths.
    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int VAL_W       = 32;
    localparam int STEP_W      = 31;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CMD_W       = 2;
    localparam int S_TDATA_W   = 136;
    localparam int M_TDATA_W   = 80;

    // Command carried in tuser of the input word.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_REG   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_SPARE = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS = 1'b0,
        CFG_REFRESH    = 1'b1
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CTRL,
        ST_INC,
        ST_DEC
    } t_state;

    // Entry fields of an input word.
    typedef struct packed {
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] upper;
        logic [STEP_W-1:0]       step;
        logic signed [VAL_W-1:0] start;
    } t_entry;

    // Limits and step as held in the limit memory.
    typedef struct packed {
        logic signed [VAL_W-1:0] lower;
        logic signed [VAL_W-1:0] upper;
        logic [STEP_W-1:0]       step;
    } t_limits;

    // Input tdata layout, last field in the lowest bits.
    typedef struct packed {
        logic [2:0]              pad;
        logic [IDX_W-1:0]        read_slot;
        logic signed [VAL_W-1:0] entry_initial;
        logic [STEP_W-1:0]       entry_increment;
        logic signed [VAL_W-1:0] entry_upper;
        logic signed [VAL_W-1:0] entry_lower;
        logic                    key_three_rise;
        logic                    key_two_rise;
        logic                    key_one_down;
    } t_s_word;

    // Output tdata layout, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]              pad;
        logic                    register_refused;
        logic [CNT_W-1:0]        entry_count;
        logic signed [VAL_W-1:0] read_result;
        logic                    refresh_pulse;
        logic                    stop_pulse;
        logic signed [VAL_W-1:0] current_setting;
        logic [IDX_W-1:0]        current_slot;
        logic                    tuning_on;
    } t_m_word;

    // Control from the sequencer to the value table.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_sel;
        logic [IDX_W-1:0] rd_slot;
        logic             reg_en;
        logic [IDX_W-1:0] reg_addr;
        logic             fwd;
        logic             inc_en;
        logic             up;
        logic             dn;
        logic             wb_en;
    } t_tbl_ctl;

endpackage

>>> src/bpt_table.sv
`timescale 1ns / 1ps

module bpt_table (
    input  logic                             i_clk,
    input  bpt_pkg::t_tbl_ctl                i_ctl,
    input  bpt_pkg::t_entry                  i_entry,
    output logic signed [bpt_pkg::VAL_W-1:0] o_setting,
    output logic signed [bpt_pkg::VAL_W-1:0] o_read
);
    import bpt_pkg::*;

    localparam int WIDE_W = VAL_W + 2;

    // Setting memory with two read ports, limit memory with one.
    logic signed [VAL_W-1:0] r_set_mem [MAX_ENTRIES];
    t_limits                 r_lim_mem [MAX_ENTRIES];

    logic signed [VAL_W-1:0] r_rd_a;
    logic signed [VAL_W-1:0] r_rd_b;
    t_limits                 r_lim;
    logic                    r_fwd;
    logic [IDX_W-1:0]        r_wb_addr;
    logic signed [VAL_W-1:0] r_mid;

    logic signed [VAL_W-1:0]  base;
    logic signed [WIDE_W-1:0] step_w;
    logic signed [WIDE_W-1:0] sum_w;
    logic signed [WIDE_W-1:0] diff_w;
    logic signed [VAL_W-1:0]  inc_val;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [VAL_W-1:0]  wr_data;

    // A registration that writes the entry being read hands its start value on.
    assign base   = r_fwd ? i_entry.start : r_rd_a;
    assign step_w = $signed({3'b000, r_lim.step});

    // Increment stage: wide sum, clamped to the upper limit.
    assign sum_w   = WIDE_W'(base) + step_w;
    assign inc_val = (sum_w <= WIDE_W'(r_lim.upper)) ? sum_w[VAL_W-1:0] : r_lim.upper;

    // Decrement stage: wide difference, clamped to the lower limit.
    assign diff_w = WIDE_W'(r_mid) - step_w;

    always_comb begin
        if (!i_ctl.dn) begin
            o_setting = r_mid;
        end else if (diff_w >= WIDE_W'(r_lim.lower)) begin
            o_setting = diff_w[VAL_W-1:0];
        end else begin
            o_setting = r_lim.lower;
        end
    end

    assign o_read = r_rd_b;

    // Single write port shared by registration and write-back.
    assign wr_en   = i_ctl.reg_en | i_ctl.wb_en;
    assign wr_addr = i_ctl.reg_en ? i_ctl.reg_addr : r_wb_addr;
    assign wr_data = i_ctl.reg_en ? i_entry.start : o_setting;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_set_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.reg_en) begin
            r_lim_mem[i_ctl.reg_addr] <= '{lower: i_entry.lower,
                                           upper: i_entry.upper,
                                           step:  i_entry.step};
        end
    end

    // Registered reads.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_a    <= r_set_mem[i_ctl.rd_sel];
            r_rd_b    <= r_set_mem[i_ctl.rd_slot];
            r_lim     <= r_lim_mem[i_ctl.rd_sel];
            r_fwd     <= i_ctl.fwd;
            r_wb_addr <= i_ctl.rd_sel;
        end
    end

    // Intermediate value between the two clamp stages.
    always_ff @(posedge i_clk) begin
        if (i_ctl.inc_en) begin
            r_mid <= i_ctl.up ? inc_val : base;
        end
    end

endmodule

>>> src/button_parameter_tuner.sv
`timescale 1ns / 1ps

// Button parameter tuner. Holds a table of up to MAX_ENTRIES tunable values,
// each with its own limits and step, in block memories, and turns key ticks
// into tuning-mode changes, selection moves and clamped steps of the selected
// value. Each input word yields one output word. A word passes through
// acceptance, the key and counter update with the table read, the increment
// clamp, and the decrement clamp with the write-back to the setting memory.
// A new word is accepted while the previous result waits in the output
// register, but the last step holds until that register is free. Table
// entries are valid only once registered; no clearing pass runs after reset.
// Configuration writes are taken at any time through the write port.
module button_parameter_tuner (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input words.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // key_one_down, key_two_rise, key_three_rise, entry_lower, entry_upper,
    // entry_increment, entry_initial, read_slot, zero fill
    input  logic [bpt_pkg::S_TDATA_W-1:0]         i_s_tdata,
    // command
    input  logic [bpt_pkg::CMD_W-1:0]             i_s_tuser,
    // Output words.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // tuning_on, current_slot, current_setting, stop_pulse, refresh_pulse,
    // read_result, entry_count, register_refused, zero fill
    output logic [bpt_pkg::M_TDATA_W-1:0]         o_m_tdata,
    // Configuration writes.
    input  logic                                  i_cfg_we,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [bpt_pkg::TICK_W-1:0]            i_cfg_wdata
);
    import bpt_pkg::*;

    // Configuration registers.
    logic [TICK_W-1:0] r_long_ticks;
    logic [TICK_W-1:0] r_ref_period;

    // Control state.
    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [IDX_W-1:0]  r_sel, n_sel;
    logic [CNT_W-1:0]  r_filled, n_filled;
    logic [TICK_W-1:0] r_hold, n_hold;
    logic              r_long_done, n_long_done;
    logic [TICK_W-1:0] r_ref_cnt, n_ref_cnt;

    // Accepted word.
    t_cmd              r_cmd;
    logic              r_k1, r_k2, r_k3;
    t_entry            r_entry;
    logic [IDX_W-1:0]  r_slot;

    // Per-word flags.
    logic              r_stop, n_stop;
    logic              r_refresh, n_refresh;
    logic              r_refused, n_refused;
    logic              r_apply, n_apply;
    logic              r_up, r_dn;

    // Output register.
    logic              r_out_valid;
    t_m_word           r_out;

    t_s_word                 s_word;
    t_tbl_ctl                tbl_ctl;
    logic signed [VAL_W-1:0] tbl_setting;
    logic signed [VAL_W-1:0] tbl_read;
    logic                    accept;
    logic                    out_free;
    logic                    full;
    logic [TICK_W-1:0]       hold_inc;
    logic [TICK_W-1:0]       ref_inc;
    logic [IDX_W-1:0]        sel_next;
    t_m_word                 result;

    assign s_word     = t_s_word'(i_s_tdata);
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid & o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    assign full     = (r_filled >= CNT_W'(MAX_ENTRIES));
    assign hold_inc = (r_hold != '1) ? r_hold + TICK_W'(1) : r_hold;
    assign ref_inc  = r_ref_cnt + TICK_W'(1);
    assign sel_next = (({1'b0, r_sel} + CNT_W'(1)) == r_filled) ? '0 : r_sel + IDX_W'(1);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks <= TICK_W'(1000);
            r_ref_period <= TICK_W'(100);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LONG_PRESS: r_long_ticks <= i_cfg_wdata;
                CFG_REFRESH:    r_ref_period <= i_cfg_wdata;
                default:        r_long_ticks <= r_long_ticks;
            endcase
        end
    end

    // Key one, selection, refresh counter and table fill for one word.
    always_comb begin
        n_mode      = r_mode;
        n_sel       = r_sel;
        n_filled    = r_filled;
        n_hold      = r_hold;
        n_long_done = r_long_done;
        n_ref_cnt   = r_ref_cnt;
        n_stop      = 1'b0;
        n_refresh   = 1'b0;
        n_refused   = 1'b0;
        n_apply     = 1'b0;
        unique case (r_cmd) inside
            CMD_TICK: begin
                if (r_filled != '0) begin
                    if (r_k1) begin
                        n_hold = hold_inc;
                        if (hold_inc >= r_long_ticks && !r_long_done) begin
                            n_long_done = 1'b1;
                            if (r_mode) begin
                                n_mode = 1'b0;
                            end else begin
                                n_mode = 1'b1;
                                n_sel  = '0;
                                n_stop = 1'b1;
                            end
                        end
                    end else begin
                        // Short press acts on its release.
                        if (r_mode && r_hold != '0 && !r_long_done) begin
                            n_sel = sel_next;
                        end
                        n_hold      = '0;
                        n_long_done = 1'b0;
                    end
                    // A tick that leaves tuning mode is still served.
                    if (r_mode) begin
                        n_apply = 1'b1;
                        if (ref_inc >= r_ref_period) begin
                            n_ref_cnt = '0;
                            n_refresh = 1'b1;
                        end else begin
                            n_ref_cnt = ref_inc;
                        end
                    end
                end
            end
            CMD_REG: begin
                if (full) begin
                    n_refused = 1'b1;
                end else begin
                    n_filled = r_filled + CNT_W'(1);
                end
            end
            CMD_READ, CMD_SPARE: begin
                n_apply = 1'b0;
            end
            default: begin
                n_apply = 1'b0;
            end
        endcase
    end

    // Sequencer: next state and table control.
    always_comb begin
        n_state          = r_state;
        tbl_ctl          = '0;
        tbl_ctl.rd_sel   = n_sel;
        tbl_ctl.rd_slot  = r_slot;
        tbl_ctl.reg_addr = r_filled[IDX_W-1:0];
        tbl_ctl.up       = r_up;
        tbl_ctl.dn       = r_dn;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CTRL;
                end
            end
            ST_CTRL: begin
                tbl_ctl.rd_en  = 1'b1;
                tbl_ctl.reg_en = (r_cmd == CMD_REG) && !full;
                tbl_ctl.fwd    = tbl_ctl.reg_en && (r_filled[IDX_W-1:0] == n_sel);
                n_state        = ST_INC;
            end
            ST_INC: begin
                tbl_ctl.inc_en = 1'b1;
                n_state        = ST_DEC;
            end
            ST_DEC: begin
                if (out_free) begin
                    tbl_ctl.wb_en = r_apply;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state update in the control step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_sel       <= '0;
            r_filled    <= '0;
            r_hold      <= '0;
            r_long_done <= 1'b0;
            r_ref_cnt   <= '0;
        end else if (r_state == ST_CTRL) begin
            r_mode      <= n_mode;
            r_sel       <= n_sel;
            r_filled    <= n_filled;
            r_hold      <= n_hold;
            r_long_done <= n_long_done;
            r_ref_cnt   <= n_ref_cnt;
        end
    end

    // Word capture and per-word flags.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= t_cmd'(i_s_tuser);
            r_k1    <= s_word.key_one_down;
            r_k2    <= s_word.key_two_rise;
            r_k3    <= s_word.key_three_rise;
            r_entry <= '{lower: s_word.entry_lower,
                         upper: s_word.entry_upper,
                         step:  s_word.entry_increment,
                         start: s_word.entry_initial};
            r_slot  <= s_word.read_slot;
        end
        if (r_state == ST_CTRL) begin
            r_stop    <= n_stop;
            r_refresh <= n_refresh;
            r_refused <= n_refused;
            r_apply   <= n_apply;
            r_up      <= n_apply & r_k2;
            r_dn      <= n_apply & r_k3;
        end
    end

    bpt_table u_table (
        .i_clk     (i_clk),
        .i_ctl     (tbl_ctl),
        .i_entry   (r_entry),
        .o_setting (tbl_setting),
        .o_read    (tbl_read)
    );

    // Result word assembly.
    always_comb begin
        result                  = '0;
        result.tuning_on        = r_mode;
        result.current_slot     = r_sel;
        result.current_setting  = (r_filled != '0) ? tbl_setting : '0;
        result.stop_pulse       = r_stop;
        result.refresh_pulse    = r_refresh;
        result.read_result      = ((r_cmd == CMD_READ) && ({1'b0, r_slot} < r_filled))
                                  ? tbl_read : '0;
        result.entry_count      = r_filled;
        result.register_refused = r_refused;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DEC && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DEC && out_free) begin
            r_out <= result;
        end
    end

    // Checks.
    a_sel_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_filled != '0) |-> ({1'b0, r_sel} < r_filled))
        else $error("selection points past the filled part of the table");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= CNT_W'(MAX_ENTRIES))
        else $error("table fill count beyond capacity");

    a_stop_in_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_pulse) |-> r_out.tuning_on)
        else $error("stop pulse without tuning mode");

    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.register_refused)
        |-> (r_out.entry_count == CNT_W'(MAX_ENTRIES)))
        else $error("registration refused while table has room");

endmodule

>>> test/button_parameter_tuner_tb.sv
`timescale 1ns / 1ps

module button_parameter_tuner_tb;
    import bpt_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 900;
    localparam int MAX_PRINTED  = 30;

    // Block ports, all driven to known values from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    // key_one_down, key_two_rise, key_three_rise, entry_lower, entry_upper,
    // entry_increment, entry_initial, read_slot, zero fill
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    // command
    logic [CMD_W-1:0]     i_s_tuser   = CMD_TICK;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    // tuning_on, current_slot, current_setting, stop_pulse, refresh_pulse,
    // read_result, entry_count, register_refused, zero fill
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LONG_PRESS;
    logic [TICK_W-1:0]    i_cfg_wdata = '0;

    button_parameter_tuner dut (.*);

    // Tuner state as this bench expects it to be.
    logic [TICK_W-1:0]       long_press_cfg = 16'd1000;
    logic [TICK_W-1:0]       refresh_cfg    = 16'd100;
    logic                    tuning_mode    = 1'b0;
    logic [IDX_W-1:0]        sel            = '0;
    logic [CNT_W-1:0]        n_entries      = '0;
    logic [TICK_W-1:0]       held_ticks     = '0;
    logic                    long_fired     = 1'b0;
    logic [TICK_W-1:0]       refresh_ticks  = '0;
    logic signed [VAL_W-1:0] value_tab [MAX_ENTRIES];
    logic signed [VAL_W-1:0] lower_tab [MAX_ENTRIES];
    logic signed [VAL_W-1:0] upper_tab [MAX_ENTRIES];
    logic [STEP_W-1:0]       step_tab  [MAX_ENTRIES];

    // Result words still owed by the block, oldest first.
    t_m_word expected_q [$];

    int   errors      = 0;
    int   n_sent      = 0;
    int   n_useful    = 0;
    int   n_checked   = 0;
    int   n_stops     = 0;
    int   n_refresh   = 0;
    int   n_refused   = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic rx_steady   = 1'b0;
    logic calm        = 1'b0;

    // 10 ns clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out the result word of one accepted input word and moves the
    // expected state on.
    function automatic t_m_word predict_word(input t_cmd cmd, input t_s_word w);
        t_m_word                 r;
        logic                    was_active;
        longint                  wide;
        logic signed [VAL_W-1:0] rd;
        r  = '0;
        rd = '0;
        case (cmd)
            CMD_TICK: begin
                if (n_entries != 0) begin
                    was_active = tuning_mode;
                    // Key one: long hold toggles the mode, a release after a
                    // short hold moves the selection on.
                    if (w.key_one_down) begin
                        if (held_ticks != 16'hFFFF)
                            held_ticks = held_ticks + 1'b1;
                        if (held_ticks >= long_press_cfg && !long_fired) begin
                            long_fired = 1'b1;
                            if (tuning_mode) begin
                                tuning_mode = 1'b0;
                            end else begin
                                tuning_mode  = 1'b1;
                                sel          = '0;
                                r.stop_pulse = 1'b1;
                            end
                        end
                    end else begin
                        if (tuning_mode && held_ticks != 0 && !long_fired)
                            sel = IDX_W'((int'(sel) + 1) % int'(n_entries));
                        held_ticks = '0;
                        long_fired = 1'b0;
                    end
                    // Steps and redraw count still run on the tick that
                    // leaves tuning mode.
                    if (was_active) begin
                        if (w.key_two_rise) begin
                            wide = longint'(value_tab[sel]) + longint'({1'b0, step_tab[sel]});
                            value_tab[sel] = (wide <= longint'(upper_tab[sel]))
                                           ? VAL_W'(wide) : upper_tab[sel];
                        end
                        if (w.key_three_rise) begin
                            wide = longint'(value_tab[sel]) - longint'({1'b0, step_tab[sel]});
                            value_tab[sel] = (wide >= longint'(lower_tab[sel]))
                                           ? VAL_W'(wide) : lower_tab[sel];
                        end
                        refresh_ticks = refresh_ticks + 1'b1;
                        if (refresh_ticks >= refresh_cfg) begin
                            refresh_ticks   = '0;
                            r.refresh_pulse = 1'b1;
                        end
                    end
                end
            end
            CMD_REG: begin
                if (n_entries >= MAX_ENTRIES) begin
                    r.register_refused = 1'b1;
                end else begin
                    lower_tab[n_entries] = w.entry_lower;
                    upper_tab[n_entries] = w.entry_upper;
                    step_tab[n_entries]  = w.entry_increment;
                    value_tab[n_entries] = w.entry_initial;
                    n_entries            = n_entries + 1'b1;
                end
            end
            CMD_READ: begin
                if (w.read_slot < n_entries)
                    rd = value_tab[w.read_slot];
            end
            default: begin
            end
        endcase
        r.tuning_on       = tuning_mode;
        r.current_slot    = sel;
        r.current_setting = (n_entries != 0) ? value_tab[sel] : '0;
        r.read_result     = rd;
        r.entry_count     = n_entries;
        n_stops           = n_stops + r.stop_pulse;
        n_refresh         = n_refresh + r.refresh_pulse;
        n_refused         = n_refused + r.register_refused;
        return r;
    endfunction

    function automatic logic chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Input word with every field but the pad random, so that unused fields toggle too.
    function automatic t_s_word junk_word();
        logic [159:0] raw;
        t_s_word      w;
        raw   = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        w     = raw[S_TDATA_W-1:0];
        w.pad = '0;
        return w;
    endfunction

    task automatic report(input string msg);
        if (errors < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report($sformatf("%s: got %0d, expected %0d (result %0d)",
                             name, got, want, n_checked));
    endtask

    task automatic check_word(input t_m_word got);
        t_m_word want;
        if (expected_q.size() == 0) begin
            report("result word arrived with nothing expected");
        end else begin
            want = expected_q.pop_front();
            compare_field("tuning_on", got.tuning_on, want.tuning_on);
            compare_field("current_slot", got.current_slot, want.current_slot);
            compare_field("current_setting", got.current_setting, want.current_setting);
            compare_field("stop_pulse", got.stop_pulse, want.stop_pulse);
            compare_field("refresh_pulse", got.refresh_pulse, want.refresh_pulse);
            compare_field("read_result", got.read_result, want.read_result);
            compare_field("entry_count", got.entry_count, want.entry_count);
            compare_field("register_refused", got.register_refused, want.register_refused);
        end
        n_checked++;
    endtask

    // Result side: take words and stall in random stretches.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            check_word(o_m_tdata);
        if (($urandom() & 63) == 0)
            rx_steady = ($urandom_range(0, 2) == 0);
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!rx_steady && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        i_m_tready <= (stall_left == 0);
    end

    // Sends one word after a random gap and books its expected result.
    task automatic send_word(input t_cmd cmd, input t_s_word w);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= w;
        do @(posedge i_clk); while (!o_s_tready);
        if (!(cmd == CMD_SPARE || (cmd == CMD_REG && n_entries >= MAX_ENTRIES)))
            n_useful++;
        expected_q.push_back(predict_word(cmd, w));
        n_sent++;
    endtask

    task automatic tick(input logic k1, input logic k2, input logic k3);
        t_s_word w;
        w                = junk_word();
        w.key_one_down   = k1;
        w.key_two_rise   = k2;
        w.key_three_rise = k3;
        send_word(CMD_TICK, w);
    endtask

    task automatic register_entry(input logic signed [VAL_W-1:0] lo,
                                  input logic signed [VAL_W-1:0] hi,
                                  input logic [STEP_W-1:0] step,
                                  input logic signed [VAL_W-1:0] start);
        t_s_word w;
        w                 = junk_word();
        w.entry_lower     = lo;
        w.entry_upper     = hi;
        w.entry_increment = step;
        w.entry_initial   = start;
        send_word(CMD_REG, w);
    endtask

    task automatic read_entry(input logic [IDX_W-1:0] slot);
        t_s_word w;
        w           = junk_word();
        w.read_slot = slot;
        send_word(CMD_READ, w);
    endtask

    // Stops sending and waits until every owed result word has arrived.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // Both registers are written back to back while the block is idle.
    task automatic write_settings(input logic [TICK_W-1:0] long_v,
                                  input logic [TICK_W-1:0] refresh_v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LONG_PRESS;
        i_cfg_wdata <= long_v;
        @(posedge i_clk);
        i_cfg_index <= CFG_REFRESH;
        i_cfg_wdata <= refresh_v;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        long_press_cfg  = long_v;
        refresh_cfg     = refresh_v;
    endtask

    // With nothing registered every tick is ignored; reads and the spare
    // command answer zero.
    task automatic test_empty_table();
        tick(1'b1, 1'b1, 1'b1);
        read_entry(3'd0);
        send_word(CMD_SPARE, junk_word());
    endtask

    // One entry at the limits of the value range: the sum must be taken wide
    // before clamping, and a short press wraps back to the same entry.
    task automatic test_first_entry();
        write_settings(16'd2, 16'd2);
        register_entry(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b0, 1'b1, 1'b0);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b0, 1'b0, 1'b1);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        read_entry(3'd0);
        read_entry(3'd7);
    endtask

    // Inverted limits, a zero step, both keys in one tick, and keys still
    // served on the tick that leaves tuning mode.
    task automatic test_entry_cases();
        register_entry(32'sd50, -32'sd50, 31'd3, 32'sd0);
        register_entry(-32'sd5, 32'sd5, 31'd0, 32'sd5);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
        tick(1'b0, 1'b1, 1'b1);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b1, 1'b1, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
    endtask

    // Thresholds of zero fire at once.
    task automatic test_zero_thresholds();
        write_settings(16'd0, 16'd0);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b0, 1'b1, 1'b1);
        tick(1'b1, 1'b0, 1'b0);
        tick(1'b0, 1'b0, 1'b0);
    endtask

    // Phases of key gestures under several register settings, with reads,
    // registrations, spare commands and stray ticks mixed in.
    task automatic test_random_gestures(input int quota);
        int                      phase;
        int                      g;
        int                      hold;
        int                      pick;
        int                      span;
        logic [TICK_W-1:0]       long_v;
        logic [TICK_W-1:0]       refresh_v;
        logic signed [VAL_W-1:0] base;
        phase = 0;
        while (n_useful < quota) begin
            case (phase % 6)
                0:       begin long_v = 16'd1;     refresh_v = 16'd1;     end
                1:       begin long_v = 16'hFFFF;  refresh_v = 16'hFFFF;  end
                2:       begin long_v = 16'd3;     refresh_v = 16'd4;     end
                3:       begin long_v = 16'd1;     refresh_v = 16'hFFFF;  end
                4:       begin long_v = 16'hFFFF;  refresh_v = 16'd1;     end
                default: begin
                    long_v    = TICK_W'($urandom_range(2, 8));
                    refresh_v = TICK_W'($urandom_range(1, 12));
                end
            endcase
            write_settings(long_v, refresh_v);
            phase++;
            for (g = 0; g < 40 && n_useful < quota; g++) begin
                calm = chance(20);
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // A press of key one: short, or long enough to toggle.
                    if (pick < 50 || long_press_cfg > 12)
                        hold = $urandom_range(1, 4);
                    else
                        hold = int'(long_press_cfg) + $urandom_range(0, 2);
                    if (hold == 0)
                        hold = 1;
                    repeat (hold) tick(1'b1, chance(30), chance(30));
                    tick(1'b0, chance(30), chance(30));
                end else if (pick < 85) begin
                    repeat ($urandom_range(1, 4)) tick(1'b0, chance(30), chance(30));
                end else begin
                    case ($urandom_range(0, 3))
                        0: read_entry(IDX_W'($urandom_range(0, MAX_ENTRIES - 1)));
                        1: begin
                            if (chance(50)) begin
                                register_entry($urandom(), $urandom(),
                                               STEP_W'($urandom()), $urandom());
                            end else begin
                                base = $urandom();
                                span = $urandom_range(1, 1000);
                                register_entry(base - span, base + span,
                                               STEP_W'($urandom_range(0, span)), base);
                            end
                        end
                        2: send_word(CMD_SPARE, junk_word());
                        default: tick(chance(50), chance(50), chance(50));
                    endcase
                end
                // Now and then let the block run completely dry.
                if (chance(3))
                    wait_idle();
            end
        end
        calm = 1'b0;
    endtask

    // Test sequence.
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_first_entry();
        test_entry_cases();
        test_zero_thresholds();
        test_random_gestures(n_useful + RANDOM_WORDS);
        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words (%0d acting on the tuner), checked %0d results, %0d errors.",
                 n_sent, n_useful, n_checked, errors);
        $display("Tuning entered %0d times, %0d redraws, %0d refused registrations, %0d entries.",
                 n_stops, n_refresh, n_refused, n_entries);
        if (errors == 0)
            $display("button_parameter_tuner test passed");
        else
            $display("button_parameter_tuner test failed");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d result words still owed.",
                 cycle_count, expected_q.size());
        $display("button_parameter_tuner test failed");
        $finish;
    end

endmodule
